/* design/hpbe_pkg.sv */
// Package for the Hamming pair byte encoder.
// Holds the transaction payload types, the Hamming column table and the byte check function.
// No dependencies.
`default_nettype none

package hpbe_pkg;

    localparam int unsigned CHECK_W    = 5;
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [CHECK_W-1:0] HAMMING_COLUMN [16] = '{
        5'h03, 5'h05, 5'h06, 5'h07, 5'h09, 5'h0a, 5'h0b, 5'h0c,
        5'h0d, 5'h0e, 5'h0f, 5'h11, 5'h12, 5'h13, 5'h14, 5'h15
    };

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_block;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_check;
        logic       last_of_run;
    } out_t;

    typedef struct packed {
        logic push;
        logic two;
    } push_t;

    // XOR of the column values of the set bits of one byte, scanned MSB first.
    function automatic logic [CHECK_W-1:0] byte_check(input logic [7:0] b,
                                                      input logic second);
        logic [CHECK_W-1:0] acc;
        acc = '0;
        for (int k = 0; k < 8; k++) begin
            if (b[7-k]) begin
                acc = acc ^ HAMMING_COLUMN[{second, 3'(k)}];
            end
        end
        return acc;
    endfunction

endpackage

`default_nettype wire

/* design/hpbe_encoder.sv */
// Pairing state and check word logic of the Hamming pair byte encoder.
// Depends on hpbe_pkg.
`default_nettype none

module hpbe_encoder
    import hpbe_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic fire,
    input  wire in_t  item,
    output out_t      res0,
    output out_t      res1,
    output push_t     push
);

    logic               holding_first_reg;
    logic               holding_first_next;
    logic [CHECK_W-1:0] partial_check_reg;
    logic [CHECK_W-1:0] partial_check_next;
    logic [CHECK_W-1:0] full_check;
    logic               first;

    assign first      = !holding_first_reg;
    assign full_check = partial_check_reg ^ byte_check(item.data_byte, 1'b1);

    always_comb begin
        res0.out_byte    = item.data_byte;
        res0.is_check    = 1'b0;
        res0.last_of_run = first;
        res1.out_byte    = {3'b000, full_check};
        res1.is_check    = 1'b1;
        res1.last_of_run = 1'b1;
        push.push        = fire;
        push.two         = !first;

        holding_first_next = holding_first_reg;
        partial_check_next = partial_check_reg;
        if (fire) begin
            if (first && !item.end_of_block) begin
                holding_first_next = 1'b1;
                partial_check_next = byte_check(item.data_byte, 1'b0);
            end else begin
                holding_first_next = 1'b0;
                partial_check_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            holding_first_reg <= 1'b0;
            partial_check_reg <= '0;
        end else begin
            holding_first_reg <= holding_first_next;
            partial_check_reg <= partial_check_next;
        end
    end

endmodule

`default_nettype wire

/* design/hpbe_result_fifo.sv */
// Result queue of the Hamming pair byte encoder: takes one or two results per cycle,
// delivers one per cycle while m_ready is high. Depends on hpbe_pkg.
`default_nettype none

module hpbe_result_fifo
    import hpbe_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire push_t push,
    input  wire out_t  res0,
    input  wire out_t  res1,
    output logic       room,
    output logic       m_valid,
    input  wire logic  m_ready,
    output out_t       m_data
);

    out_t                  entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic [FIFO_CNT_W-1:0] count_next;
    logic [FIFO_CNT_W-1:0] push_n;
    logic                  pop;

    assign room    = count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2);
    assign m_valid = count_reg != '0;
    assign m_data  = entry_reg[rd_ptr_reg];
    assign pop     = m_valid && m_ready;

    always_comb begin
        push_n = '0;
        if (push.push) begin
            push_n = push.two ? FIFO_CNT_W'(2) : FIFO_CNT_W'(1);
        end
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(push_n);
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(pop);
        count_next  = count_reg + push_n - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push.push) begin
            entry_reg[wr_ptr_reg] <= res0;
            if (push.two) begin
                entry_reg[wr_ptr_reg + FIFO_PTR_W'(1)] <= res1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

/* design/hamming_pair_byte_encoder_core.sv */
// Top level of the Hamming pair byte encoder: input register, encoder and result queue.
// Depends on hpbe_pkg, hpbe_encoder and hpbe_result_fifo.
//
//   Channel   Direction  Handshake           Payload
//   s_        in         s_valid / s_ready   s_data (in_t): data byte, end of block
//   m_        out        m_valid / m_ready   m_data (out_t): byte, check flag, last flag
//
// An input transaction is registered in the input register and encoded into one or two
// results once the result queue has room; the results are written into the queue and
// are presented on m_ from there.
// The result channel moves one result per cycle while m_ready is high, and a pair of
// input bytes gives three results.
// Reset is synchronous and active low; it restarts the pairing and empties the queue.
// Stalled m_ready fills the four-entry queue past half, then holds in_reg and s_ready.
`default_nettype none

module hamming_pair_byte_encoder_core
    import hpbe_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire in_t  s_data,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_t      m_data
);

    logic  in_vld_reg;
    logic  in_vld_next;
    in_t   in_reg;
    logic  room;
    logic  fire;
    out_t  res0;
    out_t  res1;
    push_t push;

    assign fire        = in_vld_reg && room;
    assign s_ready     = !in_vld_reg || fire;
    assign in_vld_next = (s_valid && s_ready) || (in_vld_reg && !fire);

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else begin
            in_vld_reg <= in_vld_next;
        end
    end

    hpbe_encoder u_encoder (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (in_reg),
        .res0    (res0),
        .res1    (res1),
        .push    (push)
    );

    hpbe_result_fifo u_result_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .res0    (res0),
        .res1    (res1),
        .room    (room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

/* design/hpbe_checker.sv */
// Port-level checker for the Hamming pair byte encoder, bound to the top level.
// Depends on hpbe_pkg and hamming_pair_byte_encoder_core.
`default_nettype none

module hpbe_checker
    import hpbe_pkg::*;
(
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_valid,
    input wire logic s_ready,
    input wire in_t  s_data,
    input wire logic m_valid,
    input wire logic m_ready,
    input wire out_t m_data
);

    // A stalled input transaction stays valid and keeps its payload.
    a_s_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("input transaction changed while stalled");

    // A stalled result transaction stays valid and keeps its payload.
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result transaction changed while stalled");

    // A check byte carries only five bits.
    a_check_width: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.is_check |-> m_data.out_byte[7:5] == 3'b000)
        else $error("check byte has upper bits set");

    // A check byte always closes the results of its input.
    a_check_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.is_check |-> m_data.last_of_run)
        else $error("check byte not marked last");

    // A data byte that is not last is followed by its check byte.
    a_check_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.last_of_run |=> m_valid && m_data.is_check)
        else $error("second byte of a pair not followed by its check byte");

endmodule

bind hamming_pair_byte_encoder_core hpbe_checker u_hpbe_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

/* verif/hamming_pair_byte_encoder_core_tb.sv */
// Self-checking testbench for hamming_pair_byte_encoder_core: directed and random byte blocks.
// Results are predicted per transaction and compared in order against the m_ channel.
// Depends on hpbe_pkg and the design files.
`default_nettype none

module hamming_pair_byte_encoder_core_tb
    import hpbe_pkg::*;
();

    localparam int unsigned IDLE_LIMIT = 2000;
    localparam int unsigned DRAIN_CYCLES = 8;

    localparam logic [4:0] COLUMN_VALUE [16] = '{
        5'h03, 5'h05, 5'h06, 5'h07, 5'h09, 5'h0a, 5'h0b, 5'h0c,
        5'h0d, 5'h0e, 5'h0f, 5'h11, 5'h12, 5'h13, 5'h14, 5'h15
    };

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_t  s_data;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    out_t        expected_bytes[$];
    logic        pair_open;
    logic [4:0]  pending_check;
    int unsigned error_count;
    int unsigned burst_left;
    int unsigned idle_cycles;
    int unsigned ready_mode;
    int unsigned mode_left;

    hamming_pair_byte_encoder_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    task automatic report_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    // Check bits of one byte; the second byte of a pair uses the upper eight columns.
    function automatic logic [4:0] column_xor(input logic [7:0] b, input logic second);
        logic [4:0] acc;
        acc = '0;
        for (int k = 0; k < 8; k++) begin
            if (b[7-k]) begin
                acc ^= COLUMN_VALUE[(second ? 8 : 0) + k];
            end
        end
        return acc;
    endfunction

    function automatic void encode_byte(input logic [7:0] b, input logic eob);
        out_t data_out;
        out_t check_out;
        data_out.out_byte = b;
        data_out.is_check = 1'b0;
        if (!pair_open) begin
            data_out.last_of_run = 1'b1;
            expected_bytes.push_back(data_out);
            pair_open = !eob;
            pending_check = eob ? 5'd0 : column_xor(b, 1'b0);
        end else begin
            data_out.last_of_run = 1'b0;
            check_out.out_byte = {3'b000, pending_check ^ column_xor(b, 1'b1)};
            check_out.is_check = 1'b1;
            check_out.last_of_run = 1'b1;
            expected_bytes.push_back(data_out);
            expected_bytes.push_back(check_out);
            pair_open = 1'b0;
            pending_check = '0;
        end
    endfunction

    // Called at a rising edge; returns at the edge of acceptance or after a gap.
    task automatic send_byte(input logic [7:0] b, input logic eob);
        in_t item;
        item.data_byte = b;
        item.end_of_block = eob;
        s_valid <= 1'b1;
        s_data <= item;
        do @(posedge aclk); while (!s_ready);
        encode_byte(b, eob);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(0, 12);
        end else begin
            burst_left--;
        end
    endtask

    task automatic test_pair_extremes();
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'haa, 1'b0);
        send_byte(8'h55, 1'b1);
    endtask

    task automatic test_odd_trailing_byte();
        send_byte(8'hff, 1'b1);
        send_byte(8'h00, 1'b1);
        send_byte(8'h5a, 1'b0);
        send_byte(8'hc3, 1'b0);
        send_byte(8'h7e, 1'b0);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        send_byte(8'h81, 1'b1);
    endtask

    task automatic test_end_on_pair();
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b1);
        send_byte(8'hfe, 1'b0);
        send_byte(8'h7f, 1'b1);
    endtask

    function automatic logic [7:0] random_data();
        case ($urandom_range(0, 7))
            0: return 8'h01 << $urandom_range(0, 7);
            1: return ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
            default: return 8'($urandom);
        endcase
    endfunction

    // Mostly well-formed blocks ending on end_of_block, with some misplaced markers.
    task automatic test_random_blocks(input int unsigned count);
        int unsigned sent;
        int unsigned blk_len;
        logic eob;
        sent = 0;
        while (sent < count) begin
            blk_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                                  : $urandom_range(1, 8);
            for (int unsigned k = 0; k < blk_len; k++) begin
                eob = (k == blk_len - 1);
                if ($urandom_range(0, 19) == 0) begin
                    eob = ~eob;
                end
                send_byte(random_data(), eob);
            end
            sent += blk_len;
        end
    endtask

    always @(posedge aclk) begin
        if (mode_left == 0) begin
            ready_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(40, 300);
        end else begin
            mode_left--;
        end
        case (ready_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 3) != 0);
            2: m_ready <= ($urandom_range(0, 3) == 0);
            default: m_ready <= ((mode_left % 16) < 4);
        endcase
    end

    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_bytes.size() == 0) begin
                report_error($sformatf("unexpected result byte %02h", m_data.out_byte));
            end else begin
                want = expected_bytes.pop_front();
                if (m_data.out_byte !== want.out_byte) begin
                    report_error($sformatf("out_byte %02h, expected %02h",
                                           m_data.out_byte, want.out_byte));
                end
                if (m_data.is_check !== want.is_check) begin
                    report_error($sformatf("is_check %b, expected %b",
                                           m_data.is_check, want.is_check));
                end
                if (m_data.last_of_run !== want.last_of_run) begin
                    report_error($sformatf("last_of_run %b, expected %b",
                                           m_data.last_of_run, want.last_of_run));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("** hamming_pair_byte_encoder_core: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        error_count = 0;
        pair_open = 1'b0;
        pending_check = '0;
        burst_left = 0;
        idle_cycles = 0;
        ready_mode = 0;
        mode_left = 0;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_pair_extremes();
        test_odd_trailing_byte();
        test_end_on_pair();
        test_random_blocks(1500);

        s_valid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("** hamming_pair_byte_encoder_core: PASSED **");
        end else begin
            $display("** hamming_pair_byte_encoder_core: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* hamming_pair_byte_encoder_core.f */
design/hpbe_pkg.sv
design/hpbe_encoder.sv
design/hpbe_result_fifo.sv
design/hamming_pair_byte_encoder_core.sv
design/hpbe_checker.sv
verif/hamming_pair_byte_encoder_core_tb.sv
